// ===== design/gb3_pkg.sv =====
// Shared constants, codes and types of the 3x3 Gaussian blur block.
`default_nettype none
package gb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = COL_W + 1;
  localparam int PEND_W     = $clog2(MAX_WIDTH + 2);
  localparam int CLR_W      = COL_W + 1;
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 16;
  localparam int CMP_W      = (WCFG_W > WID_W) ? WCFG_W : WID_W;
  localparam int SUM_W      = PIX_W + 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WCFG_W-1:0] FW_RESET = 11'd640;
  localparam logic [HCFG_W-1:0] FH_RESET = 16'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    SEL_EDGE,
    SEL_CENTER,
    SEL_BLUR,
    SEL_LINE
  } sel_e;

  typedef struct packed {
    logic             is_pix;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] ic;
    logic             out_en;
    sel_e             sel;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             re;
    logic [COL_W-1:0] a_addr;
    logic [COL_W-1:0] b_addr;
    logic [COL_W-1:0] e_addr;
  } rd_t;

  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] a_data;
    logic [PIX_W-1:0] b_data;
  } wr_t;

  typedef struct packed {
    logic             active;
    logic [COL_W-1:0] addr;
  } clr_t;

endpackage
`default_nettype wire

// ===== design/gb3_in_if.sv =====
// Input stream channel carrying command and pixel beats.
`default_nettype none
interface gb3_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [gb3_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink (input valid, input cmd, input pixel_in, output ready);
endinterface
`default_nettype wire

// ===== design/gb3_out_if.sv =====
// Output stream channel carrying blurred pixel beats.
`default_nettype none
interface gb3_out_if;
  logic                       valid;
  logic                       ready;
  logic [gb3_pkg::PIX_W-1:0]  pixel_out;
  logic                       frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== design/gb3_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with write-to-read bypass.
`default_nettype none
module gb3_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/gb3_ctrl.sv =====
// Frame position tracking, configuration registers, read issue and clearing pass.
`default_nettype none
module gb3_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  gb3_in_if.sink                           in_s,
  input  logic                             adv_i,
  output logic                             s1_valid_o,
  output gb3_pkg::item_t                   s1_o,
  output gb3_pkg::rd_t                     rd_o,
  output gb3_pkg::clr_t                    clr_o
);

  logic [gb3_pkg::WCFG_W-1:0] fw_q, fw_d;
  logic [gb3_pkg::HCFG_W-1:0] fh_q, fh_d;
  logic [gb3_pkg::COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [gb3_pkg::HCFG_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [gb3_pkg::PEND_W-1:0] pend_q, pend_d;
  logic [gb3_pkg::CLR_W-1:0]  clr_q, clr_d;
  logic                       s1_valid_q, s1_valid_d;
  gb3_pkg::item_t             s1_q, s1_d;

  logic [gb3_pkg::CMP_W-1:0]  fw_ext, w_ext;
  logic [gb3_pkg::WID_W-1:0]  w;
  logic [gb3_pkg::COL_W-1:0]  wm1;
  logic [gb3_pkg::HCFG_W-1:0] h, hm1;
  logic [gb3_pkg::PEND_W-1:0] wp1, pend_e;
  logic [gb3_pkg::COL_W-1:0]  ocol_e;
  logic [gb3_pkg::HCFG_W-1:0] orow_e;
  logic                       clearing, in_fire, cfg_hit;
  logic                       at_start, pend_nz, drop, out_en, border, last;
  gb3_pkg::sel_e              sel;

  assign clearing = (clr_q != gb3_pkg::CLR_W'(gb3_pkg::MAX_WIDTH));
  assign in_s.ready = !clearing && (!s1_valid_q || adv_i);
  assign in_fire = in_s.valid && in_s.ready;
  assign cfg_hit = cfg_we_i && ((cfg_index_i == gb3_pkg::REG_FRAME_WIDTH) ||
                                (cfg_index_i == gb3_pkg::REG_FRAME_HEIGHT));

  assign fw_ext = gb3_pkg::CMP_W'(fw_q);

  always_comb begin
    if (fw_ext < gb3_pkg::CMP_W'(3)) begin
      w_ext = gb3_pkg::CMP_W'(3);
    end else if (fw_ext > gb3_pkg::CMP_W'(gb3_pkg::MAX_WIDTH)) begin
      w_ext = gb3_pkg::CMP_W'(gb3_pkg::MAX_WIDTH);
    end else begin
      w_ext = fw_ext;
    end
  end

  assign w   = gb3_pkg::WID_W'(w_ext);
  assign wm1 = gb3_pkg::COL_W'(w - gb3_pkg::WID_W'(1));
  assign h   = (fh_q < gb3_pkg::HCFG_W'(3)) ? gb3_pkg::HCFG_W'(3) : fh_q;
  assign hm1 = h - gb3_pkg::HCFG_W'(1);
  assign wp1 = gb3_pkg::PEND_W'(w) + gb3_pkg::PEND_W'(1);

  always_comb begin
    at_start = (in_row_q == '0) && (in_col_q == '0);
    pend_nz  = (pend_q != '0);
    drop     = !in_s.cmd && at_start && pend_nz && (pend_q < wp1);
    pend_e   = drop ? '0 : pend_q;
    ocol_e   = drop ? in_col_q : out_col_q;
    orow_e   = drop ? in_row_q : out_row_q;
    out_en   = in_s.cmd ? (at_start && pend_nz) : (pend_e >= wp1);
    border   = (orow_e == '0) || (orow_e == hm1) || (ocol_e == '0) || (ocol_e == wm1);
    last     = (orow_e == hm1) && (ocol_e == wm1);

    if (in_s.cmd) begin
      sel = (orow_e == hm1) ? gb3_pkg::SEL_LINE : gb3_pkg::SEL_EDGE;
    end else if (in_col_q == '0) begin
      sel = gb3_pkg::SEL_EDGE;
    end else if (border) begin
      sel = gb3_pkg::SEL_CENTER;
    end else begin
      sel = gb3_pkg::SEL_BLUR;
    end

    fw_d      = fw_q;
    fh_d      = fh_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;

    if (cfg_hit) begin
      if (cfg_index_i == gb3_pkg::REG_FRAME_WIDTH) begin
        fw_d = cfg_data_i[gb3_pkg::WCFG_W-1:0];
      end else begin
        fh_d = cfg_data_i[gb3_pkg::HCFG_W-1:0];
      end
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pend_d    = '0;
    end else if (in_fire) begin
      if (in_s.cmd) begin
        pend_d = out_en ? (pend_q - gb3_pkg::PEND_W'(1)) : pend_q;
      end else begin
        pend_d = out_en ? pend_e : (pend_e + gb3_pkg::PEND_W'(1));
        if (in_col_q == wm1) begin
          in_col_d = '0;
          in_row_d = (in_row_q == hm1) ? '0 : (in_row_q + gb3_pkg::HCFG_W'(1));
        end else begin
          in_col_d = in_col_q + gb3_pkg::COL_W'(1);
        end
      end
      out_col_d = ocol_e;
      out_row_d = orow_e;
      if (out_en) begin
        if (ocol_e == wm1) begin
          out_col_d = '0;
          out_row_d = (orow_e == hm1) ? '0 : (orow_e + gb3_pkg::HCFG_W'(1));
        end else begin
          out_col_d = ocol_e + gb3_pkg::COL_W'(1);
        end
      end
    end
  end

  always_comb begin
    s1_valid_d = in_fire || (s1_valid_q && !adv_i);
    s1_d = s1_q;
    if (in_fire) begin
      s1_d.is_pix = !in_s.cmd;
      s1_d.pix    = in_s.pixel_in;
      s1_d.ic     = in_col_q;
      s1_d.out_en = out_en;
      s1_d.sel    = sel;
      s1_d.last   = last;
    end
    clr_d = clearing ? (clr_q + gb3_pkg::CLR_W'(1)) : clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= gb3_pkg::FW_RESET;
      fh_q       <= gb3_pkg::FH_RESET;
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      pend_q     <= '0;
      clr_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      fw_q       <= fw_d;
      fh_q       <= fh_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      pend_q     <= pend_d;
      clr_q      <= clr_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  assign rd_o.re     = in_fire;
  assign rd_o.a_addr = in_s.cmd ? ocol_e : in_col_q;
  assign rd_o.b_addr = in_col_q;
  assign rd_o.e_addr = wm1;

  assign clr_o.active = clearing;
  assign clr_o.addr   = clr_q[gb3_pkg::COL_W-1:0];

endmodule
`default_nettype wire

// ===== design/gb3_win.sv =====
// Window shift, line store write-back, kernel sum and output register.
`default_nettype none
module gb3_win (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s1_valid_i,
  input  gb3_pkg::item_t             s1_i,
  input  logic [gb3_pkg::PIX_W-1:0]  a_rd_i,
  input  logic [gb3_pkg::PIX_W-1:0]  b_rd_i,
  input  logic [gb3_pkg::PIX_W-1:0]  e_rd_i,
  output logic                       adv_o,
  output gb3_pkg::wr_t               wr_o,
  gb3_out_if.source                  out_s
);

  logic [gb3_pkg::PIX_W-1:0] win_q [3][2];
  logic [gb3_pkg::PIX_W-1:0] n00, n01, n02, n10, n11, n12, n20, n21, n22;
  logic [gb3_pkg::SUM_W-1:0] sum;
  logic [gb3_pkg::PIX_W-1:0] val;
  logic                      fire1;
  logic                      out_valid_q, out_valid_d;
  logic [gb3_pkg::PIX_W-1:0] out_pix_q;
  logic                      out_last_q;

  assign adv_o = !out_valid_q || out_s.ready;
  assign fire1 = s1_valid_i && adv_o;

  assign n00 = win_q[0][0];
  assign n01 = win_q[0][1];
  assign n02 = b_rd_i;
  assign n10 = win_q[1][0];
  assign n11 = win_q[1][1];
  assign n12 = a_rd_i;
  assign n20 = win_q[2][0];
  assign n21 = win_q[2][1];
  assign n22 = s1_i.pix;

  always_comb begin
    sum = gb3_pkg::SUM_W'(n00) + gb3_pkg::SUM_W'(n02) + gb3_pkg::SUM_W'(n20)
        + gb3_pkg::SUM_W'(n22)
        + (gb3_pkg::SUM_W'(n01) << 1) + (gb3_pkg::SUM_W'(n10) << 1)
        + (gb3_pkg::SUM_W'(n12) << 1) + (gb3_pkg::SUM_W'(n21) << 1)
        + (gb3_pkg::SUM_W'(n11) << 2);
    case (s1_i.sel)
      gb3_pkg::SEL_EDGE:   val = e_rd_i;
      gb3_pkg::SEL_CENTER: val = n11;
      gb3_pkg::SEL_BLUR:   val = sum[gb3_pkg::SUM_W-1:4];
      gb3_pkg::SEL_LINE:   val = a_rd_i;
      default:             val = n11;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire1 && s1_i.is_pix) begin
      win_q[0][0] <= n01;
      win_q[0][1] <= n02;
      win_q[1][0] <= n11;
      win_q[1][1] <= n12;
      win_q[2][0] <= n21;
      win_q[2][1] <= n22;
    end
  end

  assign wr_o.we     = fire1 && s1_i.is_pix;
  assign wr_o.addr   = s1_i.ic;
  assign wr_o.a_data = s1_i.pix;
  assign wr_o.b_data = a_rd_i;

  always_comb begin
    if (fire1 && s1_i.out_en) begin
      out_valid_d = 1'b1;
    end else if (out_s.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1 && s1_i.out_en) begin
      out_pix_q  <= val;
      out_last_q <= s1_i.last;
    end
  end

  assign out_s.valid      = out_valid_q;
  assign out_s.pixel_out  = out_pix_q;
  assign out_s.frame_last = out_last_q;

endmodule
`default_nettype wire

// ===== design/gaussian_blur_3x3.sv =====
// Top level of the streaming 3x3 Gaussian blur with two line stores.
`default_nettype none
// Streams 8-bit grayscale pixels in raster order and returns each pixel blurred with the
// 1-2-1 by 1-2-1 kernel, border pixels passed through raw, trailing the input by one line
// plus one pixel. The block takes one beat per clock as long as results are taken at the
// same rate; a result leaves through the item stage register, loaded with the read of the
// line stores, followed by the output register. Flush beats with cmd high drain the last
// line of a frame once its final pixel is in. After reset the line stores are cleared at
// all 1024 addresses, during which no input beat is taken. Write frame_width and
// frame_height only while idle; a write restarts the frame and drops pending results.
module gaussian_blur_3x3 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  gb3_in_if.sink                          in_s,
  gb3_out_if.source                       out_s
);

  logic                      s1_valid;
  gb3_pkg::item_t            s1;
  gb3_pkg::rd_t              rd;
  gb3_pkg::wr_t              wr;
  gb3_pkg::clr_t             clr;
  logic                      adv;
  logic [gb3_pkg::PIX_W-1:0] a_rd, b_rd, e_rd;
  logic                      mem_we;
  logic [gb3_pkg::COL_W-1:0] mem_waddr;
  logic [gb3_pkg::PIX_W-1:0] a_wdata, b_wdata;

  gb3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_s        (in_s),
    .adv_i       (adv),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1),
    .rd_o        (rd),
    .clr_o       (clr)
  );

  assign mem_we    = clr.active || wr.we;
  assign mem_waddr = clr.active ? clr.addr : wr.addr;
  assign a_wdata   = clr.active ? '0 : wr.a_data;
  assign b_wdata   = clr.active ? '0 : wr.b_data;

  gb3_ram #(.DEPTH(gb3_pkg::MAX_WIDTH), .WIDTH(gb3_pkg::PIX_W)) u_line_a (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (a_wdata),
    .re_i    (rd.re),
    .raddr_i (rd.a_addr),
    .rdata_o (a_rd)
  );

  gb3_ram #(.DEPTH(gb3_pkg::MAX_WIDTH), .WIDTH(gb3_pkg::PIX_W)) u_line_b (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (b_wdata),
    .re_i    (rd.re),
    .raddr_i (rd.b_addr),
    .rdata_o (b_rd)
  );

  // A second copy of the older line store serves the read of its last column.
  gb3_ram #(.DEPTH(gb3_pkg::MAX_WIDTH), .WIDTH(gb3_pkg::PIX_W)) u_line_b_edge (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (b_wdata),
    .re_i    (rd.re),
    .raddr_i (rd.e_addr),
    .rdata_o (e_rd)
  );

  gb3_win u_win (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .a_rd_i     (a_rd),
    .b_rd_i     (b_rd),
    .e_rd_i     (e_rd),
    .adv_o      (adv),
    .wr_o       (wr),
    .out_s      (out_s)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) clr.active |-> !in_s.ready)
    else $error("input beat taken during line store clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni) clr.active |-> !wr.we)
    else $error("pixel write-back collides with clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_s.valid) |-> $past(s1_valid))
    else $error("result appeared without an item in the compute stage");

endmodule
`default_nettype wire

// ===== sim/tb_gaussian_blur_3x3.sv =====
// Self-checking testbench for the streaming 3x3 Gaussian blur block.
`timescale 1ns / 100ps
module tb_gaussian_blur_3x3;

  localparam int LIMIT         = 3_000_000;
  localparam int N_ITEMS       = 1350;
  localparam int FINAL_CAP     = 1100;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_ROWS        = 18;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ROW_SET_WIDTH,
    ROW_SET_HEIGHT,
    ROW_PIXEL,
    ROW_FLUSH
  } row_e;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_VAL
  } chk_e;

  typedef struct packed {
    logic [gb3_pkg::PIX_W-1:0] pix;
    logic                      last;
  } blur_t;

  typedef struct packed {
    row_e        kind;
    logic [15:0] arg;
    chk_e        chk;
    blur_t       want;
  } row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_data_i;

  gb3_in_if  px_in ();
  gb3_out_if px_out ();

  gaussian_blur_3x3 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_s        (px_in),
    .out_s       (px_out)
  );

  always begin
    #1 clk_i = 1'b0;
    #1 clk_i = 1'b1;
  end

  logic [gb3_pkg::PIX_W-1:0]  prev_line  [gb3_pkg::MAX_WIDTH];
  logic [gb3_pkg::PIX_W-1:0]  older_line [gb3_pkg::MAX_WIDTH];
  logic [gb3_pkg::PIX_W-1:0]  nbhd [3][3];
  int unsigned                put_row, put_col, get_row, get_col;
  logic [gb3_pkg::WCFG_W-1:0] fw_reg;
  logic [gb3_pkg::HCFG_W-1:0] fh_reg;

  blur_t       due_pixels [$];
  int          mismatches = 0;
  int          stream_items = 0;
  int          src_calm = 0;
  int unsigned cycles = 0;

  // The directed frame is 3x3 after both registers clamp up from zero: a flush with nothing
  // pending, a flush in mid-frame, then every border beat and a drain by flushes.
  row_t plan [N_ROWS] = '{
    '{ROW_SET_WIDTH,  16'd0,   CHK_MODEL, '{8'd0,   1'b0}},
    '{ROW_SET_HEIGHT, 16'd0,   CHK_MODEL, '{8'd0,   1'b0}},
    '{ROW_FLUSH,      16'd0,   CHK_NONE,  '{8'd0,   1'b0}},
    '{ROW_PIXEL,      16'd0,   CHK_NONE,  '{8'd0,   1'b0}},
    '{ROW_PIXEL,      16'd255, CHK_NONE,  '{8'd0,   1'b0}},
    '{ROW_FLUSH,      16'd0,   CHK_NONE,  '{8'd0,   1'b0}},
    '{ROW_PIXEL,      16'd0,   CHK_NONE,  '{8'd0,   1'b0}},
    '{ROW_PIXEL,      16'd255, CHK_NONE,  '{8'd0,   1'b0}},
    '{ROW_PIXEL,      16'd255, CHK_VAL,   '{8'd0,   1'b0}},
    '{ROW_PIXEL,      16'd255, CHK_VAL,   '{8'd255, 1'b0}},
    '{ROW_PIXEL,      16'd0,   CHK_VAL,   '{8'd0,   1'b0}},
    '{ROW_PIXEL,      16'd255, CHK_VAL,   '{8'd255, 1'b0}},
    '{ROW_PIXEL,      16'd0,   CHK_MODEL, '{8'd0,   1'b0}},
    '{ROW_FLUSH,      16'd0,   CHK_VAL,   '{8'd255, 1'b0}},
    '{ROW_FLUSH,      16'd0,   CHK_VAL,   '{8'd0,   1'b0}},
    '{ROW_FLUSH,      16'd0,   CHK_VAL,   '{8'd255, 1'b0}},
    '{ROW_FLUSH,      16'd0,   CHK_VAL,   '{8'd0,   1'b1}},
    '{ROW_FLUSH,      16'd0,   CHK_NONE,  '{8'd0,   1'b0}}
  };

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void step_pos(inout int unsigned row, inout int unsigned col,
                                   input int unsigned w, input int unsigned h);
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endfunction

  function automatic bit predict_blur(input cmd_e cmd, input logic [gb3_pkg::PIX_W-1:0] pix,
                                      output blur_t res);
    int unsigned w, h, ic, orow, ocol, il, ol, pend, sum;
    bit at_start;
    logic [gb3_pkg::PIX_W-1:0] rim, a_pix, b_pix, val;
    w = fw_reg;
    if (w < 3) w = 3;
    if (w > gb3_pkg::MAX_WIDTH) w = gb3_pkg::MAX_WIDTH;
    h = fh_reg;
    if (h < 3) h = 3;
    il = put_row * w + put_col;
    ol = get_row * w + get_col;
    pend = (il >= ol) ? il - ol : il + w * h - ol;
    at_start = (put_row == 0 && put_col == 0);
    orow = get_row;
    ocol = get_col;
    res = '0;
    if (cmd == CMD_FLUSH) begin
      if (!at_start || pend == 0) return 1'b0;
      val = (orow == h - 1 && ocol < w) ? prev_line[ocol] : older_line[w - 1];
    end else begin
      if (at_start && pend != 0 && pend < w + 1) begin
        get_row = put_row;
        get_col = put_col;
        pend = 0;
        orow = get_row;
        ocol = get_col;
      end
      ic = (put_col >= w) ? 0 : put_col;
      rim = older_line[w - 1];
      a_pix = prev_line[ic];
      b_pix = older_line[ic];
      for (int r = 0; r < 3; r++) begin
        nbhd[r][0] = nbhd[r][1];
        nbhd[r][1] = nbhd[r][2];
      end
      nbhd[0][2] = b_pix;
      nbhd[1][2] = a_pix;
      nbhd[2][2] = pix;
      older_line[ic] = a_pix;
      prev_line[ic] = pix;
      step_pos(put_row, put_col, w, h);
      if (pend < w + 1) return 1'b0;
      if (ic == 0) begin
        val = rim;
      end else if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) begin
        val = nbhd[1][1];
      end else begin
        sum = nbhd[0][0] + 2 * nbhd[0][1] + nbhd[0][2]
            + 2 * nbhd[1][0] + 4 * nbhd[1][1] + 2 * nbhd[1][2]
            + nbhd[2][0] + 2 * nbhd[2][1] + nbhd[2][2];
        val = 8'(sum >> 4);
      end
    end
    res.pix = val;
    res.last = (orow == h - 1 && ocol == w - 1);
    step_pos(get_row, get_col, w, h);
    return 1'b1;
  endfunction

  task automatic send_beat(input cmd_e cmd, input logic [gb3_pkg::PIX_W-1:0] pix,
                           input chk_e chk, input blur_t typed, output bit made);
    int gap;
    blur_t got;
    if (src_calm > 0) begin
      src_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 199) == 0) src_calm = $urandom_range(30, 150);
      gap = idle_span();
    end
    if (gap > 0) begin
      px_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    px_in.valid    <= 1'b1;
    px_in.cmd      <= cmd;
    px_in.pixel_in <= pix;
    do @(posedge clk_i); while (!(px_in.valid && px_in.ready));
    made = predict_blur(cmd, pix, got);
    case (chk)
      CHK_MODEL: begin
        if (made) due_pixels.push_back(got);
      end
      CHK_VAL: begin
        due_pixels.push_back(typed);
      end
      default: begin
      end
    endcase
  endtask

  task automatic stream_beat(input cmd_e cmd);
    logic [gb3_pkg::PIX_W-1:0] pix;
    bit made;
    if ($urandom_range(0, 9) == 0) pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    else pix = 8'($urandom);
    send_beat(cmd, pix, CHK_MODEL, '0, made);
    if (cmd == CMD_PIXEL || made) stream_items++;
  endtask

  task automatic settle_block();
    px_in.valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gb3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gb3_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gb3_pkg::REG_FRAME_WIDTH) fw_reg = data[gb3_pkg::WCFG_W-1:0];
    else if (idx == gb3_pkg::REG_FRAME_HEIGHT) fh_reg = data[gb3_pkg::HCFG_W-1:0];
    put_row = 0;
    put_col = 0;
    get_row = 0;
    get_col = 0;
  endtask

  task automatic blur_phase(input logic [15:0] w_word, input logic [15:0] h_word,
                            input int n_frames, input int pix_cap);
    int w, h, npix, cut, left, tail;
    w = int'(w_word[gb3_pkg::WCFG_W-1:0]);
    if (w < 3) w = 3;
    if (w > gb3_pkg::MAX_WIDTH) w = gb3_pkg::MAX_WIDTH;
    h = int'(h_word);
    if (h < 3) h = 3;
    settle_block();
    if ($urandom_range(0, 1) == 1) begin
      write_reg(gb3_pkg::REG_FRAME_WIDTH, w_word);
      write_reg(gb3_pkg::REG_FRAME_HEIGHT, h_word);
    end else begin
      write_reg(gb3_pkg::REG_FRAME_HEIGHT, h_word);
      write_reg(gb3_pkg::REG_FRAME_WIDTH, w_word);
    end
    left = pix_cap;
    for (int f = 0; f < n_frames; f++) begin
      npix = w * h;
      cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, npix - 1) : npix;
      if (pix_cap > 0 && cut > left) cut = left;
      for (int i = 0; i < cut; i++) begin
        if ($urandom_range(0, 49) == 0) stream_beat(CMD_FLUSH);
        stream_beat(CMD_PIXEL);
      end
      left -= cut;
      if (cut < npix) return;
      tail = $urandom_range(0, 9);
      if (tail < 4 && f < n_frames - 1) begin
      end else if (tail < 8) begin
        repeat (w + 1 + $urandom_range(0, 2)) stream_beat(CMD_FLUSH);
      end else begin
        repeat ($urandom_range(1, w)) stream_beat(CMD_FLUSH);
      end
    end
  endtask

  always @(posedge clk_i) begin : check_out
    blur_t want;
    if (rst_ni && px_out.valid && px_out.ready) begin
      if (due_pixels.size() == 0) begin
        $error("unexpected beat: pixel_out %0d, frame_last %0d",
               px_out.pixel_out, px_out.frame_last);
        mismatches++;
      end else begin
        want = due_pixels.pop_front();
        if (px_out.pixel_out !== want.pix) begin
          $error("pixel_out: expected %0d, actual %0d", want.pix, px_out.pixel_out);
          mismatches++;
        end
        if (px_out.frame_last !== want.last) begin
          $error("frame_last: expected %0d, actual %0d", want.last, px_out.frame_last);
          mismatches++;
        end
      end
    end
  end

  initial begin : sink_side
    int hold;
    int calm;
    hold = 0;
    calm = 0;
    px_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 299) == 0) calm = $urandom_range(50, 200);
      if (hold > 0) begin
        hold--;
        px_out.ready <= 1'b0;
      end else begin
        px_out.ready <= 1'b1;
        if (calm == 0) hold = idle_span();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    bit made;
    logic [15:0] w_word, h_word;
    int sel, cap;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = gb3_pkg::REG_FRAME_WIDTH;
    cfg_data_i     = '0;
    px_in.valid    = 1'b0;
    px_in.cmd      = CMD_PIXEL;
    px_in.pixel_in = '0;
    for (int i = 0; i < gb3_pkg::MAX_WIDTH; i++) begin
      prev_line[i]  = '0;
      older_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) nbhd[r][c] = '0;
    put_row = 0;
    put_col = 0;
    get_row = 0;
    get_col = 0;
    fw_reg  = gb3_pkg::FW_RESET;
    fh_reg  = gb3_pkg::FH_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < N_ROWS; k++) begin
      case (plan[k].kind)
        ROW_SET_WIDTH: begin
          settle_block();
          write_reg(gb3_pkg::REG_FRAME_WIDTH, plan[k].arg);
        end
        ROW_SET_HEIGHT: begin
          settle_block();
          write_reg(gb3_pkg::REG_FRAME_HEIGHT, plan[k].arg);
        end
        ROW_PIXEL: begin
          send_beat(CMD_PIXEL, plan[k].arg[7:0], plan[k].chk, plan[k].want, made);
        end
        default: begin
          send_beat(CMD_FLUSH, 8'($urandom), plan[k].chk, plan[k].want, made);
        end
      endcase
    end

    while (stream_items < N_ITEMS - FINAL_CAP) begin
      sel = $urandom_range(0, 19);
      w_word = 16'($urandom_range(3, 12));
      h_word = 16'($urandom_range(3, 8));
      cap = 0;
      if (sel < 2) begin
        w_word = 16'($urandom_range(0, 2));
      end else if (sel == 2) begin
        w_word = 16'($urandom_range(1025, 2047));
        cap = $urandom_range(1030, 1100);
      end else if (sel == 3) begin
        w_word = 16'($urandom_range(13, 40));
      end else if (sel >= 17 && sel < 19) begin
        h_word = 16'($urandom_range(0, 2));
      end else if (sel == 19) begin
        h_word = 16'($urandom_range(9, 65535));
        cap = $urandom_range(60, 200);
      end
      if ($urandom_range(0, 7) == 0) w_word[15:11] = 5'($urandom);
      blur_phase(w_word, h_word, $urandom_range(1, 4), cap);
    end

    blur_phase(16'd2047, 16'hFFFF, 1, FINAL_CAP);

    settle_block();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
